FILE: src/ffha_pkg.sv
package ffha_pkg;

    localparam int HEAP_BYTES   = 65536;
    localparam int HEADER_BYTES = 20;

    localparam int WORDS     = HEAP_BYTES / 4;
    localparam int HDR_WORDS = (HEADER_BYTES + 3) / 4;
    localparam int HDR_BYTES = HDR_WORDS * 4;
    localparam int FOOT_WORD = WORDS - HDR_WORDS;

    localparam int IDX_W  = $clog2(WORDS);
    localparam int LINK_W = $clog2(WORDS + 1);
    // byte sizes and payload lengths, with one spare bit for the header add
    localparam int CMP_W  = (((IDX_W + 3) > 17) ? (IDX_W + 3) : 17) + 1;
    localparam int H_W    = (LINK_W > 16) ? LINK_W : 16;
    localparam int PA_W   = ((IDX_W + 3) > 16) ? (IDX_W + 3) : 16;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [1:0]        t_status;

    localparam t_link NIL = t_link'(WORDS);

    localparam t_status ST_DONE    = 2'd0;
    localparam t_status ST_NOFIT   = 2'd1;
    localparam t_status ST_IGNORED = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT0,
        OP_INIT1,
        OP_LOAD,
        OP_EVAL,
        OP_WR_NW,
        OP_WR_NBR,
        OP_UNLINK,
        OP_WR_CUR_FIN,
        OP_SET_FAIL,
        OP_SET_IGN,
        OP_SET_FREE,
        OP_LATCH_H,
        OP_RD1,
        OP_RD2,
        OP_LATCH2,
        OP_DECIDE,
        OP_PUSH1,
        OP_PUSH2,
        OP_MA,
        OP_MB,
        OP_MC,
        OP_MD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cur_valid;
        logic fit;
        logic steps_last;
        logic split;
        logic bad;
        logic fok;
        logic ep;
        logic en;
    } t_sts;

    function automatic logic is_valid(t_link x);
        return x < t_link'(WORDS);
    endfunction

endpackage

FILE: src/first_fit_heap_allocator.sv
// First-fit heap allocator over a 64 KiB heap of 4-byte words with 20-byte block headers.
// Each request item gives one result item: allocate returns the payload byte offset of the
// first free block whose payload is strictly larger than the size rounded up to four bytes,
// splitting it when the remainder exceeds a header; free merges the block with free address
// neighbors or pushes it on the free list head. The four link tables are single-port RAMs
// with a registered read, so each visited free block passes a check and an evaluate state.
// An allocate then splits the block or unlinks it and writes its result; a free reads the
// header and both neighbors, then merges or pushes the block, or is ignored when bad.
// The result then passes to the output register, waiting while that register still holds
// an unread result. After reset the block writes the initial heap headers before it takes
// the first item.
module first_fit_heap_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // size_bytes[15:0], block_addr[31:16]
    input  logic        s_axis_tuser,  // req_type[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // payload_addr[15:0]
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    ffha_pkg::t_cmd w_cmd;
    ffha_pkg::t_sts w_sts;

    ffha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_req       (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffha_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_req          (s_axis_tuser),
        .i_size         (s_axis_tdata[15:0]),
        .i_addr         (s_axis_tdata[31:16]),
        .o_sts          (w_sts),
        .o_status       (m_axis_tuser),
        .o_payload_addr (m_axis_tdata)
    );

endmodule

FILE: src/ffha_ram.sv
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/ffha_dp.sv
module ffha_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffha_pkg::t_cmd    i_cmd,
    input  logic              i_req,
    input  logic [15:0]       i_size,
    input  logic [15:0]       i_addr,
    output ffha_pkg::t_sts    o_sts,
    output ffha_pkg::t_status o_status,
    output logic [15:0]       o_payload_addr
);

    localparam int IW = ffha_pkg::IDX_W;
    localparam int CW = ffha_pkg::CMP_W;

    function automatic logic [CW-1:0] pay(ffha_pkg::t_link n, ffha_pkg::t_link c);
        logic [CW-1:0] lim;
        lim = CW'(c) + CW'(ffha_pkg::HDR_WORDS);
        if (ffha_pkg::is_valid(n) && (CW'(n) > lim)) begin
            return (CW'(n) - lim) << 2;
        end
        return '0;
    endfunction

    ffha_pkg::t_link r_cur, n_cur, r_steps, n_steps;
    ffha_pkg::t_link r_n, n_n, r_p, n_p, r_nf, n_nf, r_pf, n_pf;
    ffha_pkg::t_link r_pbn, n_pbn, r_nbp, n_nbp, r_nfp, n_nfp, r_pfp, n_pfp;
    ffha_pkg::t_link r_nfn, n_nfn, r_pfn, n_pfn, r_nbn, n_nbn;
    ffha_pkg::t_link r_head, n_head;
    logic [CW-1:0]   r_bytes, n_bytes;
    logic            r_bad, n_bad, r_fok, n_fok, r_ep, n_ep, r_en, n_en;
    ffha_pkg::t_status r_res_st, n_res_st, r_out_st, n_out_st;
    logic [15:0]     r_res_pa, n_res_pa, r_out_pa, n_out_pa;

    logic            w_nb_we, w_pb_we, w_nf_we, w_pf_we;
    logic [IW-1:0]   w_nb_addr, w_pb_addr, w_nf_addr, w_pf_addr;
    ffha_pkg::t_link w_nb_wd, w_pb_wd, w_nf_wd, w_pf_wd;
    ffha_pkg::t_link w_nb_rd, w_pb_rd, w_nf_rd, w_pf_rd;

    logic [CW-1:0]   w_pay_rd, w_pay_r, w_bytes_in;
    ffha_pkg::t_link w_nw, w_m;
    logic [ffha_pkg::H_W-1:0]  w_h;
    logic [ffha_pkg::PA_W-1:0] w_pa;
    logic            w_bad_in, w_fit, w_split, w_fok, w_ep, w_en;

    ffha_ram #(.WIDTH(ffha_pkg::LINK_W), .DEPTH(ffha_pkg::WORDS)) u_nb (
        .i_clk(i_clk), .i_we(w_nb_we), .i_addr(w_nb_addr), .i_wdata(w_nb_wd), .o_rdata(w_nb_rd)
    );
    ffha_ram #(.WIDTH(ffha_pkg::LINK_W), .DEPTH(ffha_pkg::WORDS)) u_pb (
        .i_clk(i_clk), .i_we(w_pb_we), .i_addr(w_pb_addr), .i_wdata(w_pb_wd), .o_rdata(w_pb_rd)
    );
    ffha_ram #(.WIDTH(ffha_pkg::LINK_W), .DEPTH(ffha_pkg::WORDS)) u_nf (
        .i_clk(i_clk), .i_we(w_nf_we), .i_addr(w_nf_addr), .i_wdata(w_nf_wd), .o_rdata(w_nf_rd)
    );
    ffha_ram #(.WIDTH(ffha_pkg::LINK_W), .DEPTH(ffha_pkg::WORDS)) u_pf (
        .i_clk(i_clk), .i_we(w_pf_we), .i_addr(w_pf_addr), .i_wdata(w_pf_wd), .o_rdata(w_pf_rd)
    );

    always_comb begin
        w_bytes_in = (CW'(i_size) + CW'(3)) & ~CW'(3);
        w_h        = (ffha_pkg::H_W'(i_addr) - ffha_pkg::H_W'(ffha_pkg::HDR_BYTES)) >> 2;
        w_bad_in   = (i_addr[1:0] != 2'd0) || (i_addr < 16'(ffha_pkg::HDR_BYTES))
                     || (w_h >= ffha_pkg::H_W'(ffha_pkg::FOOT_WORD));
        w_pay_rd   = pay(w_nb_rd, r_cur);
        w_pay_r    = pay(r_n, r_cur);
        w_fit      = w_pay_rd > r_bytes;
        w_split    = w_pay_r > (r_bytes + CW'(ffha_pkg::HDR_BYTES));
        w_nw       = ffha_pkg::LINK_W'(CW'(r_cur) + CW'(ffha_pkg::HDR_WORDS) + (r_bytes >> 2));
        w_pa       = (ffha_pkg::PA_W'(r_cur) << 2) + ffha_pkg::PA_W'(ffha_pkg::HDR_BYTES);
        w_m        = r_ep ? r_p : r_cur;
        // block named by the header must be confirmed by both neighbors and not be free
        w_fok      = ffha_pkg::is_valid(r_n) && (r_n > r_cur) && (r_pbn == r_cur)
                     && ((r_cur == '0) ? !ffha_pkg::is_valid(r_p)
                                       : (ffha_pkg::is_valid(r_p) && (r_nbp == r_cur)))
                     && !(ffha_pkg::is_valid(r_pf) || ffha_pkg::is_valid(r_nf)
                          || (r_cur == r_head));
        w_ep       = ffha_pkg::is_valid(r_p) && (ffha_pkg::is_valid(r_pfp)
                     || ffha_pkg::is_valid(r_nfp) || (r_p == r_head));
        w_en       = ffha_pkg::is_valid(r_n) && (ffha_pkg::is_valid(r_pfn)
                     || ffha_pkg::is_valid(r_nfn) || (r_n == r_head));
    end

    always_comb begin
        o_sts.cur_valid  = ffha_pkg::is_valid(r_cur);
        o_sts.fit        = w_fit;
        o_sts.steps_last = (r_steps + 1'b1) == ffha_pkg::t_link'(ffha_pkg::WORDS);
        o_sts.split      = w_split;
        o_sts.bad        = r_bad;
        o_sts.fok        = r_fok;
        o_sts.ep         = r_ep;
        o_sts.en         = r_en;
    end

    always_comb begin
        w_nb_we = 1'b0; w_pb_we = 1'b0; w_nf_we = 1'b0; w_pf_we = 1'b0;
        w_nb_addr = r_cur[IW-1:0]; w_pb_addr = r_cur[IW-1:0];
        w_nf_addr = r_cur[IW-1:0]; w_pf_addr = r_cur[IW-1:0];
        w_nb_wd = '0; w_pb_wd = '0; w_nf_wd = '0; w_pf_wd = '0;

        n_cur = r_cur; n_steps = r_steps; n_bytes = r_bytes; n_bad = r_bad;
        n_n = r_n; n_p = r_p; n_nf = r_nf; n_pf = r_pf;
        n_pbn = r_pbn; n_nbp = r_nbp; n_nfp = r_nfp; n_pfp = r_pfp;
        n_nfn = r_nfn; n_pfn = r_pfn; n_nbn = r_nbn;
        n_head = r_head; n_fok = r_fok; n_ep = r_ep; n_en = r_en;
        n_res_st = r_res_st; n_res_pa = r_res_pa;
        n_out_st = r_out_st; n_out_pa = r_out_pa;

        unique case (i_cmd.op)
            ffha_pkg::OP_NONE: begin
            end
            ffha_pkg::OP_INIT0: begin
                w_nb_addr = '0; w_pb_addr = '0; w_nf_addr = '0; w_pf_addr = '0;
                w_nb_we = 1'b1; w_nb_wd = ffha_pkg::t_link'(ffha_pkg::FOOT_WORD);
                w_pb_we = 1'b1; w_pb_wd = ffha_pkg::NIL;
                w_nf_we = 1'b1; w_nf_wd = ffha_pkg::NIL;
                w_pf_we = 1'b1; w_pf_wd = ffha_pkg::NIL;
            end
            ffha_pkg::OP_INIT1: begin
                w_nb_addr = IW'(ffha_pkg::FOOT_WORD); w_pb_addr = IW'(ffha_pkg::FOOT_WORD);
                w_nf_addr = IW'(ffha_pkg::FOOT_WORD); w_pf_addr = IW'(ffha_pkg::FOOT_WORD);
                w_nb_we = 1'b1; w_nb_wd = ffha_pkg::NIL;
                w_pb_we = 1'b1; w_pb_wd = '0;
                w_nf_we = 1'b1; w_nf_wd = ffha_pkg::NIL;
                w_pf_we = 1'b1; w_pf_wd = ffha_pkg::NIL;
            end
            ffha_pkg::OP_LOAD: begin
                n_cur   = i_req ? ffha_pkg::LINK_W'(w_h) : r_head;
                n_steps = '0;
                n_bytes = w_bytes_in;
                n_bad   = w_bad_in;
            end
            ffha_pkg::OP_EVAL: begin
                n_n = w_nb_rd; n_p = w_pb_rd; n_nf = w_nf_rd; n_pf = w_pf_rd;
                if (!w_fit) begin
                    n_cur   = w_nf_rd;
                    n_steps = r_steps + 1'b1;
                end
            end
            ffha_pkg::OP_WR_NW: begin
                w_nb_addr = w_nw[IW-1:0]; w_pb_addr = w_nw[IW-1:0];
                w_nf_addr = w_nw[IW-1:0]; w_pf_addr = w_nw[IW-1:0];
                w_nb_we = 1'b1; w_nb_wd = r_n;
                w_pb_we = 1'b1; w_pb_wd = r_cur;
                w_nf_we = 1'b1; w_nf_wd = r_nf;
                w_pf_we = 1'b1; w_pf_wd = r_pf;
            end
            ffha_pkg::OP_WR_NBR: begin
                w_nf_we = ffha_pkg::is_valid(r_pf); w_nf_addr = r_pf[IW-1:0]; w_nf_wd = w_nw;
                w_pf_we = ffha_pkg::is_valid(r_nf); w_pf_addr = r_nf[IW-1:0]; w_pf_wd = w_nw;
                w_pb_we = ffha_pkg::is_valid(r_n);  w_pb_addr = r_n[IW-1:0];  w_pb_wd = w_nw;
            end
            ffha_pkg::OP_UNLINK: begin
                w_nf_we = ffha_pkg::is_valid(r_pf); w_nf_addr = r_pf[IW-1:0]; w_nf_wd = r_nf;
                w_pf_we = ffha_pkg::is_valid(r_nf); w_pf_addr = r_nf[IW-1:0]; w_pf_wd = r_pf;
            end
            ffha_pkg::OP_WR_CUR_FIN: begin
                w_nb_we = w_split; w_nb_wd = w_nw;
                w_nf_we = 1'b1;    w_nf_wd = ffha_pkg::NIL;
                w_pf_we = 1'b1;    w_pf_wd = ffha_pkg::NIL;
                if (r_head == r_cur) begin
                    n_head = w_split ? w_nw : r_nf;
                end
                n_res_st = ffha_pkg::ST_DONE;
                n_res_pa = w_pa[15:0];
            end
            ffha_pkg::OP_SET_FAIL: begin
                n_res_st = ffha_pkg::ST_NOFIT;
                n_res_pa = '0;
            end
            ffha_pkg::OP_SET_IGN: begin
                n_res_st = ffha_pkg::ST_IGNORED;
                n_res_pa = '0;
            end
            ffha_pkg::OP_SET_FREE: begin
                n_res_st = ffha_pkg::ST_DONE;
                n_res_pa = '0;
            end
            ffha_pkg::OP_LATCH_H: begin
                n_n = w_nb_rd; n_p = w_pb_rd; n_nf = w_nf_rd; n_pf = w_pf_rd;
            end
            ffha_pkg::OP_RD1: begin
                w_pb_addr = r_n[IW-1:0];
                w_nb_addr = r_p[IW-1:0];
                w_nf_addr = r_p[IW-1:0];
                w_pf_addr = r_p[IW-1:0];
            end
            ffha_pkg::OP_RD2: begin
                n_pbn = w_pb_rd; n_nbp = w_nb_rd; n_nfp = w_nf_rd; n_pfp = w_pf_rd;
                w_nb_addr = r_n[IW-1:0];
                w_nf_addr = r_n[IW-1:0];
                w_pf_addr = r_n[IW-1:0];
            end
            ffha_pkg::OP_LATCH2: begin
                n_nbn = w_nb_rd; n_nfn = w_nf_rd; n_pfn = w_pf_rd;
            end
            ffha_pkg::OP_DECIDE: begin
                n_fok = w_fok; n_ep = w_ep; n_en = w_en;
            end
            ffha_pkg::OP_PUSH1: begin
                w_pf_we = ffha_pkg::is_valid(r_head); w_pf_addr = r_head[IW-1:0];
                w_pf_wd = r_cur;
            end
            ffha_pkg::OP_PUSH2: begin
                w_nf_we = 1'b1; w_nf_wd = r_head;
                w_pf_we = 1'b1; w_pf_wd = ffha_pkg::NIL;
                n_head  = r_cur;
            end
            ffha_pkg::OP_MA: begin
                w_nb_we = 1'b1; w_nb_addr = r_p[IW-1:0]; w_nb_wd = r_n;
                w_pb_we = ffha_pkg::is_valid(r_n); w_pb_addr = r_n[IW-1:0]; w_pb_wd = r_p;
            end
            ffha_pkg::OP_MB: begin
                w_nb_we = 1'b1; w_nb_addr = w_m[IW-1:0]; w_nb_wd = r_nbn;
                w_pb_we = ffha_pkg::is_valid(r_nbn); w_pb_addr = r_nbn[IW-1:0]; w_pb_wd = w_m;
            end
            ffha_pkg::OP_MC: begin
                if (r_ep) begin
                    // both sides merged: take the upper free block out of the list
                    w_nf_we = ffha_pkg::is_valid(r_pfn); w_nf_addr = r_pfn[IW-1:0];
                    w_nf_wd = r_nfn;
                    if (!ffha_pkg::is_valid(r_pfn)) begin
                        n_head = r_nfn;
                    end
                    w_pf_we = ffha_pkg::is_valid(r_nfn); w_pf_addr = r_nfn[IW-1:0];
                    w_pf_wd = r_pfn;
                end else begin
                    w_pf_we = 1'b1; w_pf_wd = r_pfn;
                    w_nf_we = 1'b1; w_nf_wd = r_nfn;
                end
            end
            ffha_pkg::OP_MD: begin
                w_nf_we = ffha_pkg::is_valid(r_pfn); w_nf_addr = r_pfn[IW-1:0]; w_nf_wd = r_cur;
                if (!ffha_pkg::is_valid(r_pfn)) begin
                    n_head = r_cur;
                end
                w_pf_we = ffha_pkg::is_valid(r_nfn); w_pf_addr = r_nfn[IW-1:0]; w_pf_wd = r_cur;
            end
            default: begin
            end
        endcase

        if (i_cmd.load_out) begin
            n_out_st = r_res_st;
            n_out_pa = r_res_pa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
        end else begin
            r_head <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur; r_steps <= n_steps; r_bytes <= n_bytes; r_bad <= n_bad;
        r_n <= n_n; r_p <= n_p; r_nf <= n_nf; r_pf <= n_pf;
        r_pbn <= n_pbn; r_nbp <= n_nbp; r_nfp <= n_nfp; r_pfp <= n_pfp;
        r_nfn <= n_nfn; r_pfn <= n_pfn; r_nbn <= n_nbn;
        r_fok <= n_fok; r_ep <= n_ep; r_en <= n_en;
        r_res_st <= n_res_st; r_res_pa <= n_res_pa;
        r_out_st <= n_out_st; r_out_pa <= n_out_pa;
    end

    assign o_status       = r_out_st;
    assign o_payload_addr = r_out_pa;

endmodule

FILE: src/ffha_ctrl.sv
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_req,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd o_cmd
);

    typedef enum logic [26:0] {
        S_INIT0 = 27'd1 << 0,
        S_INIT1 = 27'd1 << 1,
        S_IDLE  = 27'd1 << 2,
        S_A_CHK = 27'd1 << 3,
        S_A_EVL = 27'd1 << 4,
        S_A_DEC = 27'd1 << 5,
        S_A_NW  = 27'd1 << 6,
        S_A_NBR = 27'd1 << 7,
        S_A_UNL = 27'd1 << 8,
        S_A_FIN = 27'd1 << 9,
        S_FAIL  = 27'd1 << 10,
        S_F_CHK = 27'd1 << 11,
        S_F_LH  = 27'd1 << 12,
        S_F_RD1 = 27'd1 << 13,
        S_F_RD2 = 27'd1 << 14,
        S_F_EV  = 27'd1 << 15,
        S_F_DEC = 27'd1 << 16,
        S_F_BR  = 27'd1 << 17,
        S_F_P1  = 27'd1 << 18,
        S_F_P2  = 27'd1 << 19,
        S_F_MA  = 27'd1 << 20,
        S_F_MB  = 27'd1 << 21,
        S_F_MC  = 27'd1 << 22,
        S_F_MD  = 27'd1 << 23,
        S_F_FIN = 27'd1 << 24,
        S_IGN   = 27'd1 << 25,
        S_DONE  = 27'd1 << 26
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.op       = ffha_pkg::OP_NONE;
        o_cmd.load_out = 1'b0;
        o_in_ready     = 1'b0;

        unique case (r_state)
            S_INIT0: begin
                o_cmd.op = ffha_pkg::OP_INIT0;
                n_state  = S_INIT1;
            end
            S_INIT1: begin
                o_cmd.op = ffha_pkg::OP_INIT1;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = i_req ? S_F_CHK : S_A_CHK;
                end
            end
            S_A_CHK: begin
                n_state = i_sts.cur_valid ? S_A_EVL : S_FAIL;
            end
            S_A_EVL: begin
                o_cmd.op = ffha_pkg::OP_EVAL;
                if (i_sts.fit) begin
                    n_state = S_A_DEC;
                end else if (i_sts.steps_last) begin
                    n_state = S_FAIL;
                end else begin
                    n_state = S_A_CHK;
                end
            end
            S_A_DEC: begin
                n_state = i_sts.split ? S_A_NW : S_A_UNL;
            end
            S_A_NW: begin
                o_cmd.op = ffha_pkg::OP_WR_NW;
                n_state  = S_A_NBR;
            end
            S_A_NBR: begin
                o_cmd.op = ffha_pkg::OP_WR_NBR;
                n_state  = S_A_FIN;
            end
            S_A_UNL: begin
                o_cmd.op = ffha_pkg::OP_UNLINK;
                n_state  = S_A_FIN;
            end
            S_A_FIN: begin
                o_cmd.op = ffha_pkg::OP_WR_CUR_FIN;
                n_state  = S_DONE;
            end
            S_FAIL: begin
                o_cmd.op = ffha_pkg::OP_SET_FAIL;
                n_state  = S_DONE;
            end
            S_F_CHK: begin
                n_state = i_sts.bad ? S_IGN : S_F_LH;
            end
            S_F_LH: begin
                o_cmd.op = ffha_pkg::OP_LATCH_H;
                n_state  = S_F_RD1;
            end
            S_F_RD1: begin
                o_cmd.op = ffha_pkg::OP_RD1;
                n_state  = S_F_RD2;
            end
            S_F_RD2: begin
                o_cmd.op = ffha_pkg::OP_RD2;
                n_state  = S_F_EV;
            end
            S_F_EV: begin
                o_cmd.op = ffha_pkg::OP_LATCH2;
                n_state  = S_F_DEC;
            end
            S_F_DEC: begin
                o_cmd.op = ffha_pkg::OP_DECIDE;
                n_state  = S_F_BR;
            end
            S_F_BR: begin
                priority if (!i_sts.fok) begin
                    n_state = S_IGN;
                end else if (i_sts.ep) begin
                    n_state = S_F_MA;
                end else if (i_sts.en) begin
                    n_state = S_F_MB;
                end else begin
                    n_state = S_F_P1;
                end
            end
            S_F_P1: begin
                o_cmd.op = ffha_pkg::OP_PUSH1;
                n_state  = S_F_P2;
            end
            S_F_P2: begin
                o_cmd.op = ffha_pkg::OP_PUSH2;
                n_state  = S_F_FIN;
            end
            S_F_MA: begin
                o_cmd.op = ffha_pkg::OP_MA;
                n_state  = i_sts.en ? S_F_MB : S_F_FIN;
            end
            S_F_MB: begin
                o_cmd.op = ffha_pkg::OP_MB;
                n_state  = S_F_MC;
            end
            S_F_MC: begin
                o_cmd.op = ffha_pkg::OP_MC;
                n_state  = i_sts.ep ? S_F_FIN : S_F_MD;
            end
            S_F_MD: begin
                o_cmd.op = ffha_pkg::OP_MD;
                n_state  = S_F_FIN;
            end
            S_F_FIN: begin
                o_cmd.op = ffha_pkg::OP_SET_FREE;
                n_state  = S_DONE;
            end
            S_IGN: begin
                o_cmd.op = ffha_pkg::OP_SET_IGN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // wait for the output register to free up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;
    localparam int   N_RANDOM  = 1100;
    localparam int   IDLE_LIMIT = 40000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // size_bytes[15:0], block_addr[31:16]
    logic        s_axis_tuser = 1'b0; // req_type[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // payload_addr[15:0]
    logic [1:0]  m_axis_tuser;        // status[1:0]

    first_fit_heap_allocator DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    typedef struct {
        logic [1:0]  status;
        logic [15:0] payload_addr;
    } heap_result_t;

    typedef struct {
        logic        rtype;
        logic [15:0] size;
        logic [15:0] addr;
        logic        typed;
        logic [1:0]  status;
        logic [15:0] payload_addr;
    } plan_row_t;

    // shadow heap
    int heap_next [ffha_pkg::WORDS];
    int heap_prev [ffha_pkg::WORDS];
    int free_next [ffha_pkg::WORDS];
    int free_prev [ffha_pkg::WORDS];
    bit header_made [ffha_pkg::WORDS];
    int free_head;

    heap_result_t pending_results[$];
    logic [15:0]  live_blocks[$];
    logic [15:0]  seen_blocks[$];

    int errors = 0;
    int sent = 0;
    int received = 0;
    int n_alloc_ok = 0, n_nofit = 0, n_free_ok = 0, n_ignored = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;

    function automatic bit link_ok(int x);
        return x >= 0 && x < ffha_pkg::WORDS;
    endfunction

    function automatic bit block_is_free(int x);
        return link_ok(x) && (link_ok(free_prev[x]) || link_ok(free_next[x]) || x == free_head);
    endfunction

    function automatic int payload_len(int x);
        int n;
        n = heap_next[x];
        if (!link_ok(n) || n <= x + ffha_pkg::HDR_WORDS) return 0;
        return (n - x - ffha_pkg::HDR_WORDS) * 4;
    endfunction

    function automatic bit is_live_header(int h);
        int n, p;
        if (h >= ffha_pkg::FOOT_WORD) return 0;
        n = heap_next[h];
        if (!link_ok(n) || n <= h || heap_prev[n] != h) return 0;
        p = heap_prev[h];
        if (h == 0) begin
            if (link_ok(p)) return 0;
        end else if (!link_ok(p) || heap_next[p] != h) begin
            return 0;
        end
        return !block_is_free(h);
    endfunction

    task automatic heap_reset();
        for (int i = 0; i < ffha_pkg::WORDS; i++) begin
            heap_next[i] = 0; heap_prev[i] = 0; free_next[i] = 0; free_prev[i] = 0;
            header_made[i] = 0;
        end
        heap_next[0] = ffha_pkg::FOOT_WORD; heap_prev[0] = ffha_pkg::WORDS;
        free_next[0] = ffha_pkg::WORDS; free_prev[0] = ffha_pkg::WORDS;
        heap_next[ffha_pkg::FOOT_WORD] = ffha_pkg::WORDS;
        heap_prev[ffha_pkg::FOOT_WORD] = 0;
        free_next[ffha_pkg::FOOT_WORD] = ffha_pkg::WORDS;
        free_prev[ffha_pkg::FOOT_WORD] = ffha_pkg::WORDS;
        header_made[0] = 1; header_made[ffha_pkg::FOOT_WORD] = 1;
        free_head = 0;
    endtask

    task automatic heap_alloc(input int size, output heap_result_t r);
        int bytes, cur, steps, nw;
        bit found;
        bytes = (size + 3) & 32'hFFFF_FFFC;
        cur = free_head;
        steps = 0;
        found = 0;
        while (link_ok(cur) && steps < ffha_pkg::WORDS) begin
            if (payload_len(cur) > bytes) begin
                found = 1;
                break;
            end
            cur = free_next[cur];
            steps++;
        end
        if (!found) begin
            r.status = ffha_pkg::ST_NOFIT; r.payload_addr = '0;
            return;
        end
        if (payload_len(cur) > bytes + ffha_pkg::HDR_BYTES) begin
            nw = cur + ffha_pkg::HDR_WORDS + bytes / 4;
            header_made[nw] = 1;
            heap_next[nw] = heap_next[cur];
            heap_prev[nw] = cur;
            free_prev[nw] = free_prev[cur];
            free_next[nw] = free_next[cur];
            if (link_ok(free_prev[nw])) free_next[free_prev[nw]] = nw;
            if (link_ok(free_next[nw])) free_prev[free_next[nw]] = nw;
            if (link_ok(heap_next[nw])) heap_prev[heap_next[nw]] = nw;
            heap_next[cur] = nw;
            free_next[cur] = nw;
        end else begin
            if (link_ok(free_prev[cur])) free_next[free_prev[cur]] = free_next[cur];
            if (link_ok(free_next[cur])) free_prev[free_next[cur]] = free_prev[cur];
        end
        if (free_head == cur) free_head = free_next[cur];
        free_prev[cur] = ffha_pkg::WORDS;
        free_next[cur] = ffha_pkg::WORDS;
        r.status = ffha_pkg::ST_DONE;
        r.payload_addr = 16'(cur * 4 + ffha_pkg::HDR_BYTES);
    endtask

    task automatic heap_release(input int addr, output heap_result_t r);
        int h, p, n;
        bit ep, en;
        r.payload_addr = '0;
        r.status = ffha_pkg::ST_IGNORED;
        if (addr == 0 || (addr & 3) != 0 || addr < ffha_pkg::HDR_BYTES) return;
        h = (addr - ffha_pkg::HDR_BYTES) / 4;
        if (!is_live_header(h)) return;
        r.status = ffha_pkg::ST_DONE;
        p = heap_prev[h];
        n = heap_next[h];
        ep = block_is_free(p);
        en = block_is_free(n);
        if (!ep && !en) begin
            if (link_ok(free_head)) free_prev[free_head] = h;
            free_next[h] = free_head;
            free_prev[h] = ffha_pkg::WORDS;
            free_head = h;
            return;
        end
        if (ep) begin
            heap_next[p] = heap_next[h];
            if (link_ok(heap_next[h])) heap_prev[heap_next[h]] = p;
            h = p;
        end
        if (en) begin
            heap_next[h] = heap_next[n];
            if (link_ok(heap_next[n])) heap_prev[heap_next[n]] = h;
            if (ep) begin
                if (link_ok(free_prev[n])) free_next[free_prev[n]] = free_next[n];
                else free_head = free_next[n];
                if (link_ok(free_next[n])) free_prev[free_next[n]] = free_prev[n];
            end else begin
                free_prev[h] = free_prev[n];
                free_next[h] = free_next[n];
                if (link_ok(free_prev[h])) free_next[free_prev[h]] = h;
                else free_head = h;
                if (link_ok(free_next[h])) free_prev[free_next[h]] = h;
            end
        end
    endtask

    // a free of an aligned in-range address must name a header that exists
    function automatic logic [15:0] safe_addr(logic [15:0] a);
        int h;
        if (a == 0 || a[1:0] != 2'b00 || a < ffha_pkg::HDR_BYTES) return a;
        h = (a - ffha_pkg::HDR_BYTES) / 4;
        if (h >= ffha_pkg::FOOT_WORD || header_made[h]) return a;
        return a | 16'h1;
    endfunction

    task automatic make_request(output logic rtype, output logic [15:0] size,
                                output logic [15:0] addr);
        int pick, k;
        pick = $urandom_range(0, 99);
        size = '0;
        addr = '0;
        // keep the live population roughly bounded
        if (live_blocks.size() > 70) pick = 60 + pick % 40;
        else if (live_blocks.size() < 5) pick = pick % 55;
        if (pick < 55) begin
            rtype = REQ_ALLOC;
            k = $urandom_range(0, 99);
            if (k < 70) size = 16'($urandom_range(0, 300));
            else if (k < 92) size = 16'($urandom_range(0, 4000));
            else size = 16'($urandom);
            addr = 16'($urandom);
        end else begin
            rtype = REQ_FREE;
            size = 16'($urandom);
            k = $urandom_range(0, 99);
            if (k < 75 && live_blocks.size() > 0) begin
                pick = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[pick];
                live_blocks.delete(pick);
            end else if (k < 88 && seen_blocks.size() > 0) begin
                addr = seen_blocks[$urandom_range(0, seen_blocks.size() - 1)];
            end else if (k < 92) begin
                addr = '0;
            end else begin
                addr = safe_addr(16'($urandom));
            end
        end
    endtask

    task automatic predict(input logic rtype, input logic [15:0] size,
                           input logic [15:0] addr, output heap_result_t r);
        if (rtype == REQ_ALLOC) begin
            heap_alloc(int'(size), r);
            if (r.status == ffha_pkg::ST_DONE) begin
                live_blocks.push_back(r.payload_addr);
                seen_blocks.push_back(r.payload_addr);
            end
        end else begin
            heap_release(int'(addr), r);
        end
    endtask

    task automatic send_item(input logic rtype, input logic [15:0] size,
                             input logic [15:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= rtype;
        s_axis_tdata  <= {addr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    plan_row_t plan [17];

    initial begin
        logic        rtype;
        logic [15:0] size, addr;
        heap_result_t r;
        int burst;

        plan = '{
            '{REQ_ALLOC, 16'd0,     16'd0,    1'b1, ffha_pkg::ST_DONE,    16'd20},
            '{REQ_ALLOC, 16'd0,     16'd0,    1'b1, ffha_pkg::ST_DONE,    16'd40},
            '{REQ_FREE,  16'hFFFF,  16'd0,    1'b1, ffha_pkg::ST_IGNORED, 16'd0},
            '{REQ_FREE,  16'd0,     16'd1,    1'b1, ffha_pkg::ST_IGNORED, 16'd0},
            '{REQ_FREE,  16'd0,     16'd16,   1'b1, ffha_pkg::ST_IGNORED, 16'd0},
            '{REQ_FREE,  16'd0,     16'hFFFF, 1'b1, ffha_pkg::ST_IGNORED, 16'd0},
            '{REQ_ALLOC, 16'hFFFF,  16'd0,    1'b1, ffha_pkg::ST_NOFIT,   16'd0},
            '{REQ_FREE,  16'd0,     16'd20,   1'b1, ffha_pkg::ST_DONE,    16'd0},
            '{REQ_FREE,  16'd0,     16'd40,   1'b1, ffha_pkg::ST_DONE,    16'd0},
            '{REQ_FREE,  16'd0,     16'd20,   1'b1, ffha_pkg::ST_IGNORED, 16'd0},
            '{REQ_ALLOC, 16'd65496, 16'd0,    1'b1, ffha_pkg::ST_NOFIT,   16'd0},
            '{REQ_ALLOC, 16'd65492, 16'hFFFF, 1'b1, ffha_pkg::ST_DONE,    16'd20},
            '{REQ_ALLOC, 16'd0,     16'd0,    1'b1, ffha_pkg::ST_NOFIT,   16'd0},
            '{REQ_FREE,  16'd0,     16'd20,   1'b1, ffha_pkg::ST_DONE,    16'd0},
            '{REQ_ALLOC, 16'd100,   16'd0,    1'b0, ffha_pkg::ST_DONE,    16'd0},
            '{REQ_ALLOC, 16'd1,     16'd0,    1'b0, ffha_pkg::ST_DONE,    16'd0},
            '{REQ_ALLOC, 16'd200,   16'd0,    1'b0, ffha_pkg::ST_DONE,    16'd0}
        };

        heap_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            predict(plan[i].rtype, plan[i].size, plan[i].addr, r);
            if (plan[i].typed) begin
                r.status = plan[i].status;
                r.payload_addr = plan[i].payload_addr;
            end
            pending_results.push_back(r);
            send_item(plan[i].rtype, plan[i].size, plan[i].addr);
        end
        // coalescing on the last three adjacent blocks: isolated free, merge after,
        // merge on both sides
        begin
            logic [15:0] a0, a1, a2;
            a0 = live_blocks[live_blocks.size() - 3];
            a1 = live_blocks[live_blocks.size() - 2];
            a2 = live_blocks[live_blocks.size() - 1];
            live_blocks.delete();
            predict(REQ_FREE, 16'd0, a1, r); pending_results.push_back(r);
            send_item(REQ_FREE, 16'd0, a1);
            predict(REQ_FREE, 16'd0, a0, r); pending_results.push_back(r);
            send_item(REQ_FREE, 16'd0, a0);
            predict(REQ_FREE, 16'd0, a2, r); pending_results.push_back(r);
            send_item(REQ_FREE, 16'd0, a2);
        end

        burst = $urandom_range(1, 20);
        for (int n = 0; n < N_RANDOM; n++) begin
            make_request(rtype, size, addr);
            predict(rtype, size, addr, r);
            pending_results.push_back(r);
            send_item(rtype, size, addr);
            if (--burst == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
                burst = $urandom_range(1, 40);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("%0d requests: %0d allocations, %0d without fit, %0d frees, %0d ignored frees",
                 sent, n_alloc_ok, n_nofit, n_free_ok, n_ignored);
        $display("directed edge cases, coalescing on both sides and a long output stall included");
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // output side: stall pattern rotates through always ready, half ready and mostly ready, plus one long hold
    int rx_cycle = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 1;
        if (!hold_done && received == 300) begin
            hold_done <= 1'b1;
            hold_left <= 500;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case ((rx_cycle / 64) % 3)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        heap_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            received <= received + 1;
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: status %0d payload_addr %0d",
                       m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata !== want.payload_addr) begin
                    $error("payload_addr: expected %0d, got %0d", want.payload_addr,
                           m_axis_tdata);
                    errors++;
                end
                case (want.status)
                    ffha_pkg::ST_NOFIT: n_nofit++;
                    ffha_pkg::ST_IGNORED: n_ignored++;
                    default: if (want.payload_addr != 0) n_alloc_ok++; else n_free_ok++;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (stim_done && pending_results.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: nothing accepted for %0d cycles", IDLE_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
